// ----- design/redundant_wear_leveled_byte_store_defines.svh -----
// ----------------------------------------------------------------------------
// Byte store assertion macros
// Shared property templates for the wear-leveled byte store checks.
// ----------------------------------------------------------------------------
`ifndef REDUNDANT_WEAR_LEVELED_BYTE_STORE_DEFINES_SVH
`define REDUNDANT_WEAR_LEVELED_BYTE_STORE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define RWLBS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define RWLBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rwlbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rwlbs_pkg
// Widths, codes and types shared by the wear-leveled byte store files.
// ----------------------------------------------------------------------------
package rwlbs_pkg;

   localparam int MAX_SLOTS_DEF  = 256;
   localparam int MAX_COPIES_DEF = 5;

   localparam int OP_W         = 3;
   localparam int DATA_W       = 8;
   localparam int START_W      = 8;
   localparam int BADDR_W      = 11;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 9;
   localparam int SLOT_COUNT_W = 9;
   localparam int COPIES_W     = 3;

   localparam logic [SLOT_COUNT_W-1:0] SLOT_COUNT_RST = 9'd256;
   localparam logic [COPIES_W-1:0]     COPIES_RST     = 3'd3;
   localparam logic [DATA_W-1:0]       ERASED         = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_START   = 3'd0,
      OP_RESTORE = 3'd1,
      OP_READ    = 3'd2,
      OP_WRITE   = 3'd3,
      OP_LOAD    = 3'd4
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_COUNT = 2'd0,
      CSR_COPIES     = 2'd1
   } csr_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_STEP,
      S_BASE,
      S_WRITE,
      S_VOTE_ADDR,
      S_VOTE_DATA,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      ACT_WRITE,
      ACT_VOTE,
      ACT_LOAD,
      ACT_RESP
   } act_type;

endpackage

// ----- design/rwlbs_if.sv -----
// ----------------------------------------------------------------------------
// rwlbs channel interfaces
// Request, response and register-write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwlbs_req_if import rwlbs_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [DATA_W-1:0]  data;
   logic [START_W-1:0] start_slot;
   logic [BADDR_W-1:0] byte_address;

   modport source (output valid, output op, output data, output start_slot,
                   output byte_address, input ready);
   modport sink   (input valid, input op, input data, input start_slot,
                   input byte_address, output ready);
endinterface

interface rwlbs_rsp_if import rwlbs_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              error;

   modport source (output valid, output read_data, output error, input ready);
   modport sink   (input valid, input read_data, input error, output ready);
endinterface

interface rwlbs_csr_if import rwlbs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/redundant_wear_leveled_byte_store.sv -----
// ----------------------------------------------------------------------------
// redundant_wear_leveled_byte_store
// Keeps one logical byte in a rotating, replicated slot of a byte store. The
// store holds two header slots (current slot number, low and high byte)
// followed by MAX_SLOTS data slots, each slot kept as `copies` bytes. Ops:
// start fresh, restore pointer, read (majority vote), write (advances to the
// next slot after slot_count writes and rewrites the header) and raw byte
// load. Every request beat returns exactly one response beat. After reset the
// block sweeps all (MAX_SLOTS+2)*MAX_COPIES bytes (1290 at default parameters)
// to 0xFF, one byte per cycle; req is not ready until the sweep ends, while
// register writes are taken throughout. One request is handled at a time. All
// store traffic goes through one RAM and one shared address adder. Read votes
// on the slot copies, restore votes both header bytes, write stores the byte
// in every copy (first rewriting the header when the slot rotates), start
// fresh writes the header and erases the start slot, load writes one raw byte
// and unknown ops only respond. A vote makes two passes over the copies, an
// address and a data state per registered RAM read. A finished response sits
// in an output register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
`include "redundant_wear_leveled_byte_store_defines.svh"

module redundant_wear_leveled_byte_store import rwlbs_pkg::*; #(
   parameter int MAX_SLOTS  = MAX_SLOTS_DEF,
   parameter int MAX_COPIES = MAX_COPIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rwlbs_req_if.sink  req_chan,
   rwlbs_rsp_if.source rsp_chan,
   rwlbs_csr_if.sink  csr_chan
);

   // derived sizes
   localparam int STORE_SIZE = (MAX_SLOTS + 2) * MAX_COPIES;
   localparam int ADDR_W     = $clog2(STORE_SIZE);
   localparam int PTR_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
   localparam int POS_W      = $clog2(MAX_SLOTS + 2);
   localparam int CP_W       = $clog2(MAX_COPIES + 1);
   localparam int PROD_W     = POS_W + CP_W;

   typedef struct packed {
      act_type           act;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      logic [1:0]        next_step;
   } plan_type;

   // control state
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PTR_W-1:0]          ptr_ff, ptr_in;
   logic [CNT_W-1:0]          wc_ff, wc_in;
   logic [SLOT_COUNT_W-1:0]   slot_count_ff, slot_count_in;
   logic [COPIES_W-1:0]       copies_ff, copies_in;

   // request payload and work registers
   logic [OP_W-1:0]           op_ff, op_in;
   logic [DATA_W-1:0]         data_ff, data_in;
   logic [BADDR_W-1:0]        baddr_ff, baddr_in;
   logic                      hdr_ff, hdr_in;
   logic [1:0]                step_ff, step_in;
   logic [POS_W-1:0]          pos_ff, pos_in;
   logic [DATA_W-1:0]         val_ff, val_in;
   logic                      is_vote_ff, is_vote_in;
   logic [ADDR_W-1:0]         base_ff, base_in;
   logic [CP_W-1:0]           idx_ff, idx_in;
   logic                      pass_ff, pass_in;
   logic [DATA_W-1:0]         cand_ff, cand_in;
   logic [CP_W-1:0]           cnt_ff, cnt_in;
   logic [DATA_W-1:0]         lo_ff, lo_in;
   logic [DATA_W-1:0]         hi_ff, hi_in;
   logic                      err_ff, err_in;
   logic [DATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic                      rsp_err_ff, rsp_err_in;

   // combinational helpers
   logic [CNT_W-1:0]          slots_eff;
   logic [CP_W-1:0]           copies_eff;
   logic [CP_W-1:0]           need;
   logic                      last_copy;
   logic [ADDR_W-1:0]         mem_addr;
   logic [PROD_W-1:0]         prod;
   logic [15:0]               ptr16;
   logic [15:0]               restored_id;
   logic [POS_W-1:0]          ptr_pos;
   plan_type                  plan;

   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic [DATA_W-1:0]         mem_wdata;
   logic [DATA_W-1:0]         mem_rdata;

   logic                      req_fire;
   logic [CNT_W:0]            wc_next;
   logic                      match;
   logic [CP_W-1:0]           cnt_final;
   logic                      vote_ok;

   // ------------------------------------------------------------------------
   // Effective configuration: registers saturate into the supported range.
   // ------------------------------------------------------------------------
   always_comb begin
      if (slot_count_ff == '0) begin
         slots_eff = CNT_W'(1);
      end else if (32'(slot_count_ff) > MAX_SLOTS) begin
         slots_eff = CNT_W'(MAX_SLOTS);
      end else begin
         slots_eff = CNT_W'(slot_count_ff);
      end

      if (copies_ff == '0) begin
         copies_eff = CP_W'(1);
      end else if (32'(copies_ff) > MAX_COPIES) begin
         copies_eff = CP_W'(MAX_COPIES);
      end else begin
         copies_eff = CP_W'(copies_ff);
      end
   end

   // strict majority threshold; a single copy needs only itself
   assign need      = (copies_eff >> 1) + CP_W'(1);
   assign last_copy = (idx_ff == copies_eff - CP_W'(1));

   // shared address adder: slot base plus copy index
   assign mem_addr = base_ff + ADDR_W'(idx_ff);

   // slot base multiply, registered into base_ff before use
   assign prod = PROD_W'(pos_ff) * PROD_W'(copies_eff);

   assign ptr16       = 16'(ptr_ff);
   assign restored_id = {hi_ff, lo_ff};
   assign ptr_pos     = POS_W'(ptr_ff) + POS_W'(2);
   assign req_fire    = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------------------
   // Sequencer plan: what the current op does at its current step.
   // Header slots are positions 0 and 1, data slot s is position s+2.
   // ------------------------------------------------------------------------
   always_comb begin
      plan.act       = ACT_RESP;
      plan.pos       = '0;
      plan.val       = '0;
      plan.next_step = step_ff;
      unique case (op_ff)
         OP_START: begin
            unique case (step_ff)
               2'd0: begin
                  plan.act = ACT_WRITE; plan.pos = POS_W'(0);
                  plan.val = ptr16[7:0]; plan.next_step = 2'd1;
               end
               2'd1: begin
                  plan.act = ACT_WRITE; plan.pos = POS_W'(1);
                  plan.val = ptr16[15:8]; plan.next_step = 2'd2;
               end
               2'd2: begin
                  plan.act = ACT_WRITE; plan.pos = ptr_pos;
                  plan.val = ERASED; plan.next_step = 2'd3;
               end
               default: plan.act = ACT_RESP;
            endcase
         end
         OP_WRITE: begin
            unique case (step_ff)
               2'd0: begin
                  plan.act = ACT_WRITE;
                  if (hdr_ff) begin
                     plan.pos = POS_W'(0); plan.val = ptr16[7:0]; plan.next_step = 2'd1;
                  end else begin
                     plan.pos = ptr_pos; plan.val = data_ff; plan.next_step = 2'd3;
                  end
               end
               2'd1: begin
                  plan.act = ACT_WRITE; plan.pos = POS_W'(1);
                  plan.val = ptr16[15:8]; plan.next_step = 2'd2;
               end
               2'd2: begin
                  plan.act = ACT_WRITE; plan.pos = ptr_pos;
                  plan.val = data_ff; plan.next_step = 2'd3;
               end
               default: plan.act = ACT_RESP;
            endcase
         end
         OP_RESTORE: begin
            unique case (step_ff)
               2'd0: begin
                  plan.act = ACT_VOTE; plan.pos = POS_W'(0); plan.next_step = 2'd1;
               end
               2'd1: begin
                  plan.act = ACT_VOTE; plan.pos = POS_W'(1); plan.next_step = 2'd2;
               end
               default: plan.act = ACT_RESP;
            endcase
         end
         OP_READ: begin
            if (step_ff == 2'd0) begin
               plan.act = ACT_VOTE; plan.pos = ptr_pos; plan.next_step = 2'd1;
            end
         end
         OP_LOAD: plan.act = ACT_LOAD;
         default: plan.act = ACT_RESP;
      endcase
   end

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(STORE_SIZE - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_chan.valid) state_in = S_STEP;
         end
         S_STEP: begin
            unique case (plan.act)
               ACT_WRITE, ACT_VOTE: state_in = S_BASE;
               default:             state_in = S_RESP;
            endcase
         end
         S_BASE: state_in = is_vote_ff ? S_VOTE_ADDR : S_WRITE;
         S_WRITE: begin
            if (last_copy) state_in = S_STEP;
         end
         S_VOTE_ADDR: state_in = S_VOTE_DATA;
         S_VOTE_DATA: state_in = (last_copy && pass_ff) ? S_STEP : S_VOTE_ADDR;
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and outputs
   // ------------------------------------------------------------------------
   always_comb begin
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff;
      ptr_in        = ptr_ff;
      wc_in         = wc_ff;
      slot_count_in = slot_count_ff;
      copies_in     = copies_ff;
      op_in         = op_ff;
      data_in       = data_ff;
      baddr_in      = baddr_ff;
      hdr_in        = hdr_ff;
      step_in       = step_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      is_vote_in    = is_vote_ff;
      base_in       = base_ff;
      idx_in        = idx_ff;
      pass_in       = pass_ff;
      cand_in       = cand_ff;
      cnt_in        = cnt_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      err_in        = err_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_err_in    = rsp_err_ff;

      mem_we    = 1'b0;
      mem_waddr = mem_addr;
      mem_wdata = val_ff;

      wc_next   = (CNT_W + 1)'(wc_ff) + (CNT_W + 1)'(1);
      match     = (mem_rdata == cand_ff);
      cnt_final = cnt_ff + CP_W'(match);
      vote_ok   = (cnt_final >= need);

      // response taken downstream
      if (rsp_valid_ff && rsp_chan.ready) rsp_valid_in = 1'b0;

      // register writes, to be issued only while idle; the block does not enforce this
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_SLOT_COUNT: slot_count_in = csr_chan.data[SLOT_COUNT_W-1:0];
            CSR_COPIES:     copies_in     = csr_chan.data[COPIES_W-1:0];
            default:        ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = ERASED;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.op;
               data_in  = req_chan.data;
               baddr_in = req_chan.byte_address;
               step_in  = 2'd0;
               err_in   = 1'b0;
               lo_in    = '0;
               hi_in    = '0;
               hdr_in   = 1'b0;
               if (req_chan.op == OP_START) begin
                  // out-of-range start slot falls back to slot 0
                  if (32'(req_chan.start_slot) >= 32'(slots_eff)) begin
                     err_in = 1'b1;
                     ptr_in = '0;
                  end else begin
                     ptr_in = PTR_W'(req_chan.start_slot);
                  end
               end else if (req_chan.op == OP_WRITE) begin
                  // slot worn out: rotate and rewrite header first
                  if (wc_next > (CNT_W + 1)'(slots_eff)) begin
                     wc_in  = CNT_W'(1);
                     hdr_in = 1'b1;
                     if (32'(ptr_ff) + 1 >= 32'(slots_eff)) begin
                        ptr_in = '0;
                     end else begin
                        ptr_in = ptr_ff + PTR_W'(1);
                     end
                  end else begin
                     wc_in = wc_next[CNT_W-1:0];
                  end
               end
            end
         end
         S_STEP: begin
            step_in    = plan.next_step;
            pos_in     = plan.pos;
            val_in     = plan.val;
            is_vote_in = (plan.act == ACT_VOTE);
            if (plan.act == ACT_LOAD) begin
               // addresses past the store are dropped
               if (32'(baddr_ff) < STORE_SIZE) begin
                  mem_we    = 1'b1;
                  mem_waddr = ADDR_W'(baddr_ff);
                  mem_wdata = data_ff;
               end
            end else if (plan.act == ACT_RESP && op_ff == OP_RESTORE) begin
               if (restored_id >= 16'(slots_eff)) begin
                  err_in = 1'b1;
                  ptr_in = '0;
               end else begin
                  ptr_in = PTR_W'(restored_id);
               end
            end
         end
         S_BASE: begin
            base_in = prod[ADDR_W-1:0];
            idx_in  = '0;
            pass_in = 1'b0;
            cnt_in  = '0;
         end
         S_WRITE: begin
            mem_we = 1'b1;
            idx_in = idx_ff + CP_W'(1);
         end
         S_VOTE_ADDR: ;
         S_VOTE_DATA: begin
            idx_in = idx_ff + CP_W'(1);
            if (!pass_ff) begin
               // pass 1: majority candidate
               if (cnt_ff == '0) begin
                  cand_in = mem_rdata;
                  cnt_in  = CP_W'(1);
               end else if (match) begin
                  cnt_in = cnt_ff + CP_W'(1);
               end else begin
                  cnt_in = cnt_ff - CP_W'(1);
               end
               if (last_copy) begin
                  pass_in = 1'b1;
                  idx_in  = '0;
                  cnt_in  = '0;
               end
            end else begin
               // pass 2: confirm the candidate
               cnt_in = cnt_final;
               if (last_copy) begin
                  if (!vote_ok) err_in = 1'b1;
                  if (step_ff == 2'd2) begin
                     hi_in = vote_ok ? cand_ff : '0;
                  end else begin
                     lo_in = vote_ok ? cand_ff : '0;
                  end
               end
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = err_ff;
               rsp_data_in  = (op_ff == OP_READ) ? lo_ff : '0;
            end
         end
         default: ;
      endcase
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         ptr_ff        <= '0;
         wc_ff         <= '0;
         slot_count_ff <= SLOT_COUNT_RST;
         copies_ff     <= COPIES_RST;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
         ptr_ff        <= ptr_in;
         wc_ff         <= wc_in;
         slot_count_ff <= slot_count_in;
         copies_ff     <= copies_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      data_ff     <= data_in;
      baddr_ff    <= baddr_in;
      hdr_ff      <= hdr_in;
      step_ff     <= step_in;
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      is_vote_ff  <= is_vote_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      pass_ff     <= pass_in;
      cand_ff     <= cand_in;
      cnt_ff      <= cnt_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

   // ------------------------------------------------------------------------
   // Byte store
   // ------------------------------------------------------------------------
   rwlbs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_addr),
      .rd_data (mem_rdata)
   );

   // ports
   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.read_data = rsp_data_ff;
   assign rsp_chan.error     = rsp_err_ff;
   assign csr_chan.ready     = 1'b1;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   `RWLBS_ASSERT_NEXT(a_busy_after_beat, clock, reset, req_fire, !req_chan.ready, "request taken while busy")
   `RWLBS_ASSERT_IMP(a_ptr_range, clock, reset, 1'b1, 32'(ptr_ff) < MAX_SLOTS, "slot pointer out of range")
   `RWLBS_ASSERT_IMP(a_wc_range, clock, reset, 1'b1, 32'(wc_ff) <= MAX_SLOTS, "save count out of range")
   `RWLBS_ASSERT_IMP(a_vote_count, clock, reset, state_ff == S_VOTE_DATA, cnt_ff <= copies_eff, "vote count exceeds copies")

endmodule

// ----- design/rwlbs_ram.sv -----
// ----------------------------------------------------------------------------
// rwlbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rwlbs_ram import rwlbs_pkg::*; #(
   parameter int WIDTH = DATA_W,
   parameter int DEPTH = (MAX_SLOTS_DEF + 2) * MAX_COPIES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
